>>> rtl/core/number_to_text_console_writer_defines.svh
// Assertion macros used by the console writer top level.
`ifndef NUMBER_TO_TEXT_CONSOLE_WRITER_DEFINES_SVH
`define NUMBER_TO_TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define NTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed one cycle later");

`endif

>>> rtl/core/ntw_pkg.sv
// Shared types, constants and helper functions of the console writer.
package ntw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int VALUE_W    = 64;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 11;
    localparam int ATTR_W     = 8;
    localparam int CHAR_W     = 8;
    localparam int LINE_W     = 5;
    localparam int COL_W      = 7;
    localparam int TDATA_W    = 32;
    localparam int PAD_W      = TDATA_W - IDX_W - ATTR_W - CHAR_W;

    localparam int BCD_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int HEX_PAD_W  = BCD_W - VALUE_W;
    localparam int CNT_W      = 5;
    localparam int CONV_STEPS = 64;
    localparam int ITER_W     = 6;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [MODE_W-1:0] MODE_CHAR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SDEC    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UDEC    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HEX_PFX = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;

    typedef enum logic [2:0] {
        KIND_CHAR,
        KIND_NEWLINE,
        KIND_DEC,
        KIND_DEC_NEG,
        KIND_HEX,
        KIND_HEX_PFX
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_PFX_X,
        ST_CONVERT,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {4'h0, d};
        return (d < 4'd10) ? (CHAR_ZERO + dw) : (CHAR_LOWER_A + dw - 8'd10);
    endfunction

    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (b[4*i +: 4] >= 4'd5) begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/number_to_text_console_writer.sv
// A character goes from the queue to the output register; a decimal number runs through 64
// conversion steps of the bit-serial binary to BCD converter, then skips its leading zeros
// before its first digit; a hex number skips its leading zeros after any prefix.
// Throughput: one cell per cycle once digits come out, while m_tready is high; the back end
// takes one request at a time, and a two-entry queue takes requests meanwhile.
// Reset (rst_n, asynchronous, active low) clears cursor, queue, output and sets attribute 0x07.
`include "number_to_text_console_writer_defines.svh"

module number_to_text_console_writer #(
    parameter int COLUMNS = ntw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ntw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ntw_pkg::VALUE_W-1:0] s_tdata,  // value [63:0]
    input  logic [ntw_pkg::MODE_W-1:0]  s_tuser,  // mode [2:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ntw_pkg::TDATA_W-1:0] m_tdata,  // cell_index [10:0], cell_attribute [18:11],
                                                  // cell_character [26:19], zero [31:27]
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ntw_pkg::ATTR_W-1:0]  cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [ntw_pkg::ATTR_W-1:0] attr_reg;
    ntw_pkg::q_stat_t           q_stat;
    ntw_pkg::cmd_t              push_cmd;
    ntw_pkg::cmd_t              head_cmd;
    logic                       push;
    logic                       q_pop;
    logic                       q_grow;
    logic                       index_ok;

    assign cfg_ready = 1'b1;
    assign q_grow    = push && !q_pop;
    assign index_ok  = (CELLS >= 2048) ||
                       (m_tdata[ntw_pkg::IDX_W-1:0] < ntw_pkg::IDX_W'(CELLS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ntw_pkg::ATTR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            attr_reg <= cfg_data;
        end
    end

    ntw_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ntw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    ntw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_stat.empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .attr      (attr_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `NTW_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= ntw_pkg::QCNT_W'(ntw_pkg::QDEPTH))
    `NTW_ASSERT_NEXT(a_queue_grows, clk, rst_n, q_grow, q_stat.count == $past(q_stat.count) + 2'd1)
    `NTW_ASSERT_SAME(a_index_range, clk, rst_n, m_tvalid, index_ok)

endmodule

>>> rtl/core/ntw_front.sv
// Front end: accepts requests, sorts them by kind, negates negative signed values and drops unknown modes.
module ntw_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ntw_pkg::MODE_W-1:0]  s_tuser,
    input  logic [ntw_pkg::VALUE_W-1:0] s_tdata,
    input  ntw_pkg::q_stat_t            q_stat,
    output logic                        push,
    output ntw_pkg::cmd_t               push_cmd
);

    logic known_mode;

    assign s_tready = !q_stat.full;

    always_comb
    begin
        known_mode     = 1'b1;
        push_cmd.kind  = ntw_pkg::KIND_CHAR;
        push_cmd.value = s_tdata;
        case (s_tuser)
            ntw_pkg::MODE_CHAR:
            begin
                if (s_tdata[7:0] == ntw_pkg::CHAR_NEWLINE)
                begin
                    push_cmd.kind = ntw_pkg::KIND_NEWLINE;
                end
            end
            ntw_pkg::MODE_SDEC:
            begin
                if (s_tdata[ntw_pkg::VALUE_W-1])
                begin
                    push_cmd.kind  = ntw_pkg::KIND_DEC_NEG;
                    push_cmd.value = (~s_tdata) + 64'd1;
                end
                else
                begin
                    push_cmd.kind = ntw_pkg::KIND_DEC;
                end
            end
            ntw_pkg::MODE_UDEC:    push_cmd.kind = ntw_pkg::KIND_DEC;
            ntw_pkg::MODE_HEX:     push_cmd.kind = ntw_pkg::KIND_HEX;
            ntw_pkg::MODE_HEX_PFX: push_cmd.kind = ntw_pkg::KIND_HEX_PFX;
            default:               known_mode = 1'b0;
        endcase
    end

    assign push = s_tvalid && s_tready && known_mode;

endmodule

>>> rtl/core/ntw_queue.sv
// Short command queue between the front end and the back end.
module ntw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ntw_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output ntw_pkg::cmd_t    head_cmd,
    output ntw_pkg::q_stat_t q_stat
);

    ntw_pkg::cmd_t                   mem_reg [ntw_pkg::QDEPTH];
    logic [ntw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [ntw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [ntw_pkg::QCNT_W-1:0]      count_reg;
    logic [ntw_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == ntw_pkg::QCNT_W'(ntw_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/ntw_back.sv
// Back end: converts numbers to digits, tracks the cursor and writes cells.
module ntw_back #(
    parameter int COLUMNS = ntw_pkg::DEF_COLUMNS,
    parameter int ROWS    = ntw_pkg::DEF_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  ntw_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    input  logic [ntw_pkg::ATTR_W-1:0]  attr,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ntw_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    ntw_pkg::state_t                  state_reg;
    ntw_pkg::state_t                  state_next;
    logic [ntw_pkg::VALUE_W-1:0]      bits_reg;
    logic [ntw_pkg::BCD_W-1:0]        bcd_reg;
    logic [ntw_pkg::CNT_W-1:0]        count_reg;
    logic [ntw_pkg::ITER_W-1:0]       iter_reg;
    logic                             started_reg;
    logic                             hex_reg;
    logic [ntw_pkg::LINE_W-1:0]       line_reg;
    logic [ntw_pkg::COL_W-1:0]        col_reg;
    logic                             out_valid_reg;
    logic [ntw_pkg::TDATA_W-1:0]      out_data_reg;
    logic                             out_last_reg;

    logic                             out_free;
    logic                             emit;
    logic [ntw_pkg::CHAR_W-1:0]       emit_char;
    logic                             emit_last;
    logic                             newline;
    logic                             load;
    logic                             shift;
    logic                             step;
    logic                             skip;
    logic                             load_hex;
    logic [3:0]                       nibble;
    logic [ntw_pkg::BCD_W-1:0]        bcd_adj;
    logic [ntw_pkg::COL_W:0]          col_inc;
    logic [ntw_pkg::LINE_W:0]         line_inc;
    logic [ntw_pkg::LINE_W-1:0]       line_adv;
    logic [ntw_pkg::IDX_W:0]          idx_full;

    assign out_free = !out_valid_reg || m_tready;
    assign nibble   = bcd_reg[ntw_pkg::BCD_W-1 -: 4];
    assign bcd_adj  = ntw_pkg::bcd_adjust(bcd_reg);
    assign skip     = !started_reg && (nibble == 4'd0) && (count_reg != 5'd1);
    assign load_hex = cmd.kind inside {ntw_pkg::KIND_HEX, ntw_pkg::KIND_HEX_PFX};
    assign col_inc  = {1'b0, col_reg} + 8'd1;
    assign line_inc = {1'b0, line_reg} + 6'd1;
    assign line_adv = (line_inc >= 6'(ROWS)) ? '0 : line_inc[ntw_pkg::LINE_W-1:0];
    assign idx_full = 12'(line_reg) * 12'(COLUMNS) + 12'(col_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntw_pkg::ST_IDLE:
            begin
                if (load)
                begin
                    case (cmd.kind)
                        ntw_pkg::KIND_DEC:     state_next = ntw_pkg::ST_CONVERT;
                        ntw_pkg::KIND_DEC_NEG: state_next = ntw_pkg::ST_SIGN;
                        ntw_pkg::KIND_HEX_PFX: state_next = ntw_pkg::ST_SIGN;
                        ntw_pkg::KIND_HEX:     state_next = ntw_pkg::ST_DIGITS;
                        default:               state_next = ntw_pkg::ST_IDLE;
                    endcase
                end
            end
            ntw_pkg::ST_SIGN:
            begin
                if (emit)
                begin
                    state_next = hex_reg ? ntw_pkg::ST_PFX_X : ntw_pkg::ST_CONVERT;
                end
            end
            ntw_pkg::ST_PFX_X:
            begin
                if (emit)
                begin
                    state_next = ntw_pkg::ST_DIGITS;
                end
            end
            ntw_pkg::ST_CONVERT:
            begin
                if (iter_reg == ntw_pkg::ITER_W'(ntw_pkg::CONV_STEPS - 1))
                begin
                    state_next = ntw_pkg::ST_DIGITS;
                end
            end
            ntw_pkg::ST_DIGITS:
            begin
                if (shift && (count_reg == 5'd1))
                begin
                    state_next = ntw_pkg::ST_IDLE;
                end
            end
            default: state_next = ntw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        emit      = 1'b0;
        emit_char = ntw_pkg::CHAR_ZERO;
        emit_last = 1'b0;
        newline   = 1'b0;
        load      = 1'b0;
        shift     = 1'b0;
        step      = 1'b0;
        case (state_reg)
            ntw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        ntw_pkg::KIND_CHAR:
                        begin
                            if (out_free)
                            begin
                                cmd_pop   = 1'b1;
                                emit      = 1'b1;
                                emit_char = cmd.value[ntw_pkg::CHAR_W-1:0];
                                emit_last = 1'b1;
                            end
                        end
                        ntw_pkg::KIND_NEWLINE:
                        begin
                            cmd_pop = 1'b1;
                            newline = 1'b1;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                            load    = 1'b1;
                        end
                    endcase
                end
            end
            ntw_pkg::ST_SIGN:
            begin
                emit      = out_free;
                emit_char = hex_reg ? ntw_pkg::CHAR_ZERO : ntw_pkg::CHAR_MINUS;
            end
            ntw_pkg::ST_PFX_X:
            begin
                emit      = out_free;
                emit_char = ntw_pkg::CHAR_LOWER_X;
            end
            ntw_pkg::ST_CONVERT:
            begin
                step = 1'b1;
            end
            ntw_pkg::ST_DIGITS:
            begin
                emit_char = ntw_pkg::digit_char(nibble);
                emit_last = (count_reg == 5'd1);
                if (skip)
                begin
                    shift = 1'b1;
                end
                else if (out_free)
                begin
                    shift = 1'b1;
                    emit  = 1'b1;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntw_pkg::ST_IDLE;
            count_reg     <= '0;
            iter_reg      <= '0;
            started_reg   <= 1'b0;
            hex_reg       <= 1'b0;
            line_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                hex_reg     <= load_hex;
                count_reg   <= load_hex ? ntw_pkg::CNT_W'(ntw_pkg::HEX_DIGITS)
                                        : ntw_pkg::CNT_W'(ntw_pkg::BCD_DIGITS);
                iter_reg    <= '0;
                started_reg <= 1'b0;
            end
            if (step)
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (shift)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (shift && emit)
            begin
                started_reg <= 1'b1;
            end
            if (emit)
            begin
                if (col_inc >= 8'(COLUMNS))
                begin
                    col_reg  <= '0;
                    line_reg <= line_adv;
                end
                else
                begin
                    col_reg <= col_inc[ntw_pkg::COL_W-1:0];
                end
            end
            else if (newline)
            begin
                col_reg  <= '0;
                line_reg <= line_adv;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= emit_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bits_reg <= cmd.value;
            bcd_reg  <= load_hex ? {cmd.value, {ntw_pkg::HEX_PAD_W{1'b0}}} : '0;
        end
        else if (step)
        begin
            {bcd_reg, bits_reg} <= {bcd_adj[ntw_pkg::BCD_W-2:0], bits_reg, 1'b0};
        end
        else if (shift)
        begin
            bcd_reg <= {bcd_reg[ntw_pkg::BCD_W-5:0], 4'h0};
        end
        if (emit)
        begin
            out_data_reg <= {{ntw_pkg::PAD_W{1'b0}}, emit_char, attr,
                             idx_full[ntw_pkg::IDX_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/number_to_text_console_writer_tb.sv
// Self-checking testbench that checks the console writer's screen cell writes against a predictor.
module number_to_text_console_writer_tb;

    localparam int SCREEN_COLS = ntw_pkg::DEF_COLUMNS;
    localparam int SCREEN_ROWS = ntw_pkg::DEF_ROWS;
    localparam int DEC_BASE    = 10;
    localparam int HEX_BASE    = 16;
    localparam int SETTLE      = 120;
    localparam int MAX_PRINTS  = 40;

    localparam logic [ntw_pkg::MODE_W-1:0] MODE_RSVD_5 = 3'd5;
    localparam logic [ntw_pkg::MODE_W-1:0] MODE_RSVD_6 = 3'd6;
    localparam logic [ntw_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [ntw_pkg::IDX_W-1:0]  idx;
        logic [ntw_pkg::ATTR_W-1:0] attr;
        logic [ntw_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } cell_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ntw_pkg::VALUE_W-1:0]   s_tdata;
    logic [ntw_pkg::MODE_W-1:0]    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ntw_pkg::TDATA_W-1:0]   m_tdata;
    logic                          m_tlast;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [ntw_pkg::ATTR_W-1:0]    cfg_data;

    cell_t                         pending_cells[$];
    int                            cur_line;
    int                            cur_col;
    logic [ntw_pkg::ATTR_W-1:0]    attr_model;
    int                            errors;
    int                            send_idle_pct;
    int                            recv_stall_pct;

    number_to_text_console_writer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #(20 * 1000000);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTS)
        begin
            $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
        end
        errors++;
    endtask

    task automatic next_line();
        cur_col = 0;
        cur_line++;
        if (cur_line >= SCREEN_ROWS)
        begin
            cur_line = 0;
        end
    endtask

    task automatic put_cell(input logic [ntw_pkg::CHAR_W-1:0] ch);
        cell_t c;
        c.idx  = ntw_pkg::IDX_W'((cur_line * SCREEN_COLS + cur_col) & 'h7ff);
        c.attr = attr_model;
        c.ch   = ch;
        c.last = 1'b0;
        pending_cells.push_back(c);
        cur_col++;
        if (cur_col >= SCREEN_COLS)
        begin
            next_line();
        end
    endtask

    task automatic put_number(input logic [ntw_pkg::VALUE_W-1:0] v, input int base);
        logic [3:0] digit_buf[ntw_pkg::BCD_DIGITS];
        int         count;
        logic [3:0] d;
        count = 0;
        if (v == 0)
        begin
            put_cell(ntw_pkg::CHAR_ZERO);
        end
        else
        begin
            while (v != 0 && count < ntw_pkg::BCD_DIGITS)
            begin
                digit_buf[count] = 4'(v % base);
                v = v / base;
                count++;
            end
            while (count > 0)
            begin
                count--;
                d = digit_buf[count];
                if (d < 4'd10)
                begin
                    put_cell(ntw_pkg::CHAR_ZERO + {4'h0, d});
                end
                else
                begin
                    put_cell(ntw_pkg::CHAR_LOWER_A + {4'h0, d} - 8'd10);
                end
            end
        end
    endtask

    // Appends the cell writes that one request causes and moves the cursor.
    task automatic render_item(input logic [ntw_pkg::MODE_W-1:0] mode,
                               input logic [ntw_pkg::VALUE_W-1:0] value);
        int    start_size;
        cell_t c;
        start_size = pending_cells.size();
        case (mode)
            ntw_pkg::MODE_CHAR:
            begin
                if (value[ntw_pkg::CHAR_W-1:0] == ntw_pkg::CHAR_NEWLINE)
                begin
                    next_line();
                end
                else
                begin
                    put_cell(value[ntw_pkg::CHAR_W-1:0]);
                end
            end
            ntw_pkg::MODE_SDEC:
            begin
                if (value[ntw_pkg::VALUE_W-1])
                begin
                    put_cell(ntw_pkg::CHAR_MINUS);
                    put_number(~value + 64'd1, DEC_BASE);
                end
                else
                begin
                    put_number(value, DEC_BASE);
                end
            end
            ntw_pkg::MODE_UDEC:
            begin
                put_number(value, DEC_BASE);
            end
            ntw_pkg::MODE_HEX:
            begin
                put_number(value, HEX_BASE);
            end
            ntw_pkg::MODE_HEX_PFX:
            begin
                put_cell(ntw_pkg::CHAR_ZERO);
                put_cell(ntw_pkg::CHAR_LOWER_X);
                put_number(value, HEX_BASE);
            end
            default:
            begin
            end
        endcase
        if (pending_cells.size() > start_size)
        begin
            c = pending_cells.pop_back();
            c.last = 1'b1;
            pending_cells.push_back(c);
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cell_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_cells.size() == 0)
            begin
                report_mismatch("unexpected cell write", 64'({m_tlast, m_tdata}), 64'd0);
            end
            else
            begin
                want = pending_cells.pop_front();
                if (m_tdata[10:0] !== want.idx)
                begin
                    report_mismatch("cell_index", 64'(m_tdata[10:0]), 64'(want.idx));
                end
                if (m_tdata[18:11] !== want.attr)
                begin
                    report_mismatch("cell_attribute", 64'(m_tdata[18:11]), 64'(want.attr));
                end
                if (m_tdata[26:19] !== want.ch)
                begin
                    report_mismatch("cell_character", 64'(m_tdata[26:19]), 64'(want.ch));
                end
                if (m_tdata[31:27] !== 5'd0)
                begin
                    report_mismatch("tdata padding", 64'(m_tdata[31:27]), 64'd0);
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("last_of_run", 64'(m_tlast), 64'(want.last));
                end
            end
        end
    end

    // Leaves the request valid high after acceptance so back-to-back requests need no gap.
    task automatic send_item(input logic [ntw_pkg::MODE_W-1:0] mode,
                             input logic [ntw_pkg::VALUE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            s_tuser  <= ntw_pkg::MODE_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        render_item(mode, value);
    endtask

    task automatic drain(input int settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ntw_pkg::ATTR_W-1:0] attr);
        drain(SETTLE);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= attr;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        attr_model = attr;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ntw_pkg::VALUE_W-1:0] random_value();
        logic [ntw_pkg::VALUE_W-1:0] v;
        case ($urandom_range(5))
            0: v = 64'($urandom_range(99));
            1: v = {$urandom, $urandom};
            2: v = {$urandom, $urandom} >> $urandom_range(63);
            3:
            begin
                case ($urandom_range(3))
                    0: v = '1;
                    1: v = 64'h8000_0000_0000_0000;
                    2: v = 64'h7fff_ffff_ffff_ffff;
                    default: v = 64'd1;
                endcase
            end
            4: v = -64'($urandom_range(999));
            default: v = 64'($urandom);
        endcase
        return v;
    endfunction

    task automatic test_characters();
        send_item(ntw_pkg::MODE_CHAR, 64'h41);
        send_item(ntw_pkg::MODE_CHAR, 64'h00);
        send_item(ntw_pkg::MODE_CHAR, 64'hff);
        send_item(ntw_pkg::MODE_CHAR, 64'hffff_ffff_ffff_ff5a);
        send_item(ntw_pkg::MODE_CHAR, 64'hdead_beef_cafe_f00a);
        send_item(ntw_pkg::MODE_CHAR, 64'h0a);
    endtask

    task automatic test_signed_decimal();
        send_item(ntw_pkg::MODE_SDEC, 64'd0);
        send_item(ntw_pkg::MODE_SDEC, 64'd1);
        send_item(ntw_pkg::MODE_SDEC, '1);
        send_item(ntw_pkg::MODE_SDEC, 64'h7fff_ffff_ffff_ffff);
        send_item(ntw_pkg::MODE_SDEC, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_unsigned_decimal();
        send_item(ntw_pkg::MODE_UDEC, 64'd0);
        send_item(ntw_pkg::MODE_UDEC, '1);
    endtask

    task automatic test_hex();
        send_item(ntw_pkg::MODE_HEX, 64'd0);
        send_item(ntw_pkg::MODE_HEX, '1);
        send_item(ntw_pkg::MODE_HEX, 64'h0123_4567_89ab_cdef);
        send_item(ntw_pkg::MODE_HEX_PFX, 64'd0);
        send_item(ntw_pkg::MODE_HEX_PFX, '1);
    endtask

    task automatic test_ignored_modes();
        send_item(MODE_RSVD_5, {$urandom, $urandom});
        send_item(MODE_RSVD_6, '1);
        send_item(MODE_RSVD_7, 64'd0);
        send_item(ntw_pkg::MODE_CHAR, 64'h2a);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count, input bit pause_midway);
        int                          done;
        int                          r;
        logic [ntw_pkg::MODE_W-1:0]  mode;
        logic [ntw_pkg::VALUE_W-1:0] value;
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        done = 0;
        while (done < count)
        begin
            r     = $urandom_range(99);
            value = random_value();
            if (r < 22)
            begin
                mode = ntw_pkg::MODE_CHAR;
                value[ntw_pkg::CHAR_W-1:0] = ntw_pkg::CHAR_W'($urandom_range(255));
            end
            else if (r < 30)
            begin
                mode = ntw_pkg::MODE_CHAR;
                value[ntw_pkg::CHAR_W-1:0] = ntw_pkg::CHAR_NEWLINE;
            end
            else if (r < 46)
            begin
                mode = ntw_pkg::MODE_SDEC;
            end
            else if (r < 60)
            begin
                mode = ntw_pkg::MODE_UDEC;
            end
            else if (r < 76)
            begin
                mode = ntw_pkg::MODE_HEX;
            end
            else if (r < 92)
            begin
                mode = ntw_pkg::MODE_HEX_PFX;
            end
            else
            begin
                mode = ntw_pkg::MODE_W'($urandom_range(MODE_RSVD_7, MODE_RSVD_5));
            end
            send_item(mode, value);
            if (mode <= ntw_pkg::MODE_HEX_PFX)
            begin
                done++;
            end
            if (pause_midway && done == count / 2)
            begin
                drain(0);
                pause_midway = 1'b0;
            end
        end
    endtask

    task automatic test_attribute_and_traffic();
        write_attribute(8'h00);
        test_random_traffic(0, 0, 30, 1'b0);
        write_attribute(8'hff);
        test_random_traffic(76, 0, 30, 1'b1);
        write_attribute(8'($urandom_range(255)));
        test_random_traffic(0, 76, 30, 1'b0);
        write_attribute(ntw_pkg::ATTR_RESET);
        test_random_traffic(13, 13, 30, 1'b0);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        cur_line       = 0;
        cur_col        = 0;
        attr_model     = ntw_pkg::ATTR_RESET;
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_characters();
        test_signed_decimal();
        test_unsigned_decimal();
        test_hex();
        test_ignored_modes();
        test_attribute_and_traffic();

        drain(SETTLE);
        if (pending_cells.size() != 0)
        begin
            report_mismatch("cell writes never seen", 64'(pending_cells.size()), 64'd0);
        end
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
